// ----- rtl/tcp_reno_window_control_defines.svh -----
// assertion macros for the tcp reno window controller
// included by the top level; expects clk and rst_n in scope
`ifndef TCP_RENO_WINDOW_CONTROL_DEFINES_SVH
`define TCP_RENO_WINDOW_CONTROL_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TCPRWC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TCPRWC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tcprwc_pkg.sv -----
// shared types and constants for the tcp reno window controller
// no dependencies
package tcprwc_pkg;

    // fixed point and field widths
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int WIN_W             = 32;
    localparam int ACK_W             = 32;
    localparam int CMD_W             = 2;
    localparam int DUP_W             = 8;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_WINDOW    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_THRESHOLD = 1'b1;
    localparam logic [WIN_W-1:0] INITIAL_WINDOW_RESET    = 32'd65536;
    localparam logic [WIN_W-1:0] INITIAL_THRESHOLD_RESET = 32'd4194304;

    // duplicate ack counting
    localparam logic [DUP_W-1:0] DUP_LIMIT = 8'd3;
    localparam logic [DUP_W-1:0] DUP_MAX   = 8'hFF;

    // event codes
    typedef enum logic [CMD_W-1:0] {
        CMD_DUPACK  = 2'd0,
        CMD_NEWACK  = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_CHECK   = 2'd3
    } cmd_code_t;

    typedef enum logic {
        PHASE_OPEN     = 1'b0,
        PHASE_RECOVERY = 1'b1
    } phase_t;

    // controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_COMMIT
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic init_load;
        logic capture;
        logic div_start;
        logic commit;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic needs_div;
        logic div_done;
    } ctl_status_t;

endpackage

// ----- rtl/tcprwc_channels.sv -----
// handshake channel interfaces for events in and results out
// depends on tcprwc_pkg
interface tcprwc_event_if;
    logic                           valid;
    logic                           ready;
    logic [tcprwc_pkg::CMD_W-1:0]   command;
    logic [tcprwc_pkg::ACK_W-1:0]   ack_number;

    modport source (output valid, output command, output ack_number, input ready);
    modport sink   (input valid, input command, input ack_number, output ready);
endinterface

interface tcprwc_result_if;
    logic                           valid;
    logic                           ready;
    logic                           retransmit;
    logic [tcprwc_pkg::WIN_W-1:0]   window_now;
    logic [tcprwc_pkg::WIN_W-1:0]   threshold_now;
    logic                           in_recovery;

    modport source (output valid, output retransmit, output window_now,
                    output threshold_now, output in_recovery, input ready);
    modport sink   (input valid, input retransmit, input window_now,
                    input threshold_now, input in_recovery, output ready);
endinterface

// ----- rtl/tcprwc_recip.sv -----
// iterative restoring divider for the saturated reciprocal 2^(2*FRAC_BITS) / w
// one quotient bit per cycle; depends on tcprwc_pkg
module tcprwc_recip #(
    parameter int FRAC_BITS = tcprwc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tcprwc_pkg::WIN_W-1:0] divisor,
    output logic                         done,
    output logic [tcprwc_pkg::WIN_W-1:0] quotient
);
    localparam int W     = tcprwc_pkg::WIN_W;
    localparam int DW    = 2 * FRAC_BITS + 1;
    localparam int QW    = (DW > W) ? DW : W + 1;
    localparam int CNT_W = $clog2(DW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [W-1:0]     dsr_reg, dsr_next;

    logic             last_step;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             fits;

    // one restoring step: the dividend has a single set bit, fed in first
    assign last_step = (cnt_reg == CNT_W'(DW - 1));
    assign trial     = {rem_reg, (cnt_reg == '0)};
    assign fits      = (trial >= {1'b0, dsr_reg});
    assign diff      = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        priority if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    // saturate on zero divisor or a quotient past 32 bits
    assign done     = done_reg;
    assign quotient = ((dsr_reg == '0) || (|quo_reg[QW-1:W])) ? '1 : quo_reg[W-1:0];

endmodule

// ----- rtl/tcprwc_datapath.sv -----
// datapath: configuration, congestion state, event registers and result registers
// depends on tcprwc_pkg and tcprwc_recip
module tcprwc_datapath #(
    parameter int FRAC_BITS = tcprwc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tcprwc_pkg::ctl_cmd_t               ctl,
    output tcprwc_pkg::ctl_status_t            status,
    input  logic                               cfg_we,
    input  logic [tcprwc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcprwc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [tcprwc_pkg::CMD_W-1:0]       command,
    input  logic [tcprwc_pkg::ACK_W-1:0]       ack_number,
    output logic                               retransmit,
    output logic [tcprwc_pkg::WIN_W-1:0]       window_now,
    output logic [tcprwc_pkg::WIN_W-1:0]       threshold_now,
    output logic                               in_recovery
);
    localparam int W = tcprwc_pkg::WIN_W;
    localparam logic [W-1:0] ONE_FIXED = W'(1) << FRAC_BITS;

    logic [W-1:0]                     cfg_window_reg;
    logic [W-1:0]                     cfg_threshold_reg;

    tcprwc_pkg::cmd_code_t            cmd_reg;
    logic [tcprwc_pkg::ACK_W-1:0]     ack_reg;

    logic [W-1:0]                     window_reg, window_next;
    logic [W-1:0]                     threshold_reg, threshold_next;
    logic [tcprwc_pkg::DUP_W-1:0]     dup_count_reg, dup_count_next;
    tcprwc_pkg::phase_t               phase_reg, phase_next;
    logic [tcprwc_pkg::ACK_W-1:0]     mark_reg, mark_next;
    logic                             retransmitted_reg, retransmitted_next;

    logic                             retransmit_reg, retransmit_next;
    logic [W-1:0]                     window_now_reg;
    logic [W-1:0]                     threshold_now_reg;
    logic                             in_recovery_reg;

    logic [tcprwc_pkg::DUP_W-1:0]     dup_inc;
    logic                             slow_start;
    logic [W-1:0]                     growth;
    logic [W:0]                       grown_sum;
    logic [W-1:0]                     window_grown;
    logic [W-1:0]                     recip_q;
    logic                             recip_done;

    // configuration registers, loaded into the state once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_window_reg    <= tcprwc_pkg::INITIAL_WINDOW_RESET;
            cfg_threshold_reg <= tcprwc_pkg::INITIAL_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcprwc_pkg::CFG_INITIAL_WINDOW:    cfg_window_reg    <= cfg_data;
                tcprwc_pkg::CFG_INITIAL_THRESHOLD: cfg_threshold_reg <= cfg_data;
            endcase
        end
    end

    // event capture
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= tcprwc_pkg::cmd_code_t'(command);
            ack_reg <= ack_number;
        end
    end

    // reciprocal of the current window
    tcprwc_recip #(
        .FRAC_BITS (FRAC_BITS)
    ) u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .divisor  (window_reg),
        .done     (recip_done),
        .quotient (recip_q)
    );

    // window growth, saturating
    assign slow_start   = (window_reg < threshold_reg);
    assign growth       = slow_start ? ONE_FIXED : recip_q;
    assign grown_sum    = {1'b0, window_reg} + {1'b0, growth};
    assign window_grown = grown_sum[W] ? '1 : grown_sum[W-1:0];

    assign status.needs_div = (cmd_reg == tcprwc_pkg::CMD_NEWACK) && !slow_start;
    assign status.div_done  = recip_done;

    // event update
    always_comb
    begin
        dup_inc = (dup_count_reg == tcprwc_pkg::DUP_MAX) ? dup_count_reg
                                                        : dup_count_reg + 8'd1;
        window_next        = window_reg;
        threshold_next     = threshold_reg;
        dup_count_next     = dup_count_reg;
        phase_next         = phase_reg;
        mark_next          = mark_reg;
        retransmitted_next = retransmitted_reg;
        retransmit_next    = 1'b0;
        unique case (cmd_reg)
            tcprwc_pkg::CMD_DUPACK:
            begin
                dup_count_next = dup_inc;
                if ((phase_reg == tcprwc_pkg::PHASE_OPEN) && (dup_inc == tcprwc_pkg::DUP_LIMIT))
                begin
                    phase_next     = tcprwc_pkg::PHASE_RECOVERY;
                    mark_next      = ack_reg;
                    threshold_next = window_reg >> 1;
                    window_next    = window_reg >> 1;
                end
                if ((phase_next == tcprwc_pkg::PHASE_RECOVERY) && !retransmitted_reg)
                begin
                    retransmitted_next = 1'b1;
                    retransmit_next    = 1'b1;
                end
            end
            tcprwc_pkg::CMD_NEWACK:
            begin
                dup_count_next = '0;
                window_next    = window_grown;
                if ((phase_reg == tcprwc_pkg::PHASE_RECOVERY) && (ack_reg < mark_reg))
                begin
                    retransmit_next = 1'b1;
                end
                else
                begin
                    retransmitted_next = 1'b0;
                end
            end
            tcprwc_pkg::CMD_TIMEOUT:
            begin
                phase_next     = tcprwc_pkg::PHASE_OPEN;
                threshold_next = window_reg >> 1;
                window_next    = ONE_FIXED;
                dup_count_next = '0;
            end
            tcprwc_pkg::CMD_CHECK:
            begin
                if ((phase_reg == tcprwc_pkg::PHASE_RECOVERY) && (ack_reg > mark_reg))
                begin
                    phase_next     = tcprwc_pkg::PHASE_OPEN;
                    dup_count_next = '0;
                end
            end
        endcase
    end

    // window and threshold, loaded from configuration after reset
    always_ff @(posedge clk)
    begin
        if (ctl.init_load)
        begin
            window_reg    <= cfg_window_reg;
            threshold_reg <= cfg_threshold_reg;
        end
        else if (ctl.commit)
        begin
            window_reg    <= window_next;
            threshold_reg <= threshold_next;
        end
    end

    // loss tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dup_count_reg     <= '0;
            phase_reg         <= tcprwc_pkg::PHASE_OPEN;
            mark_reg          <= '0;
            retransmitted_reg <= 1'b0;
        end
        else if (ctl.commit)
        begin
            dup_count_reg     <= dup_count_next;
            phase_reg         <= phase_next;
            mark_reg          <= mark_next;
            retransmitted_reg <= retransmitted_next;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            retransmit_reg    <= retransmit_next;
            window_now_reg    <= window_next;
            threshold_now_reg <= threshold_next;
            in_recovery_reg   <= (phase_next == tcprwc_pkg::PHASE_RECOVERY);
        end
    end

    assign retransmit    = retransmit_reg;
    assign window_now    = window_now_reg;
    assign threshold_now = threshold_now_reg;
    assign in_recovery   = in_recovery_reg;

endmodule

// ----- rtl/tcprwc_controller.sv -----
// controller: sequences capture, reciprocal, commit and the result handshake
// depends on tcprwc_pkg
module tcprwc_controller (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  tcprwc_pkg::ctl_status_t status,
    output tcprwc_pkg::ctl_cmd_t    ctl
);
    tcprwc_pkg::ctl_state_t state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_free;

    // result slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcprwc_pkg::ST_INIT:   state_next = tcprwc_pkg::ST_IDLE;
            tcprwc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tcprwc_pkg::ST_DECIDE;
                end
            end
            tcprwc_pkg::ST_DECIDE:
            begin
                state_next = status.needs_div ? tcprwc_pkg::ST_DIV : tcprwc_pkg::ST_COMMIT;
            end
            tcprwc_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = tcprwc_pkg::ST_COMMIT;
                end
            end
            tcprwc_pkg::ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = tcprwc_pkg::ST_IDLE;
                end
            end
            default:               state_next = tcprwc_pkg::ST_INIT;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl.init_load = (state_reg == tcprwc_pkg::ST_INIT);
        ctl.capture   = (state_reg == tcprwc_pkg::ST_IDLE) && in_valid;
        ctl.div_start = (state_reg == tcprwc_pkg::ST_DECIDE) && status.needs_div;
        ctl.commit    = (state_reg == tcprwc_pkg::ST_COMMIT) && out_free;
        in_ready      = (state_reg == tcprwc_pkg::ST_IDLE);
    end

    // result valid flag
    always_comb
    begin
        priority if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcprwc_pkg::ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/tcp_reno_window_control.sv -----
// top level of the tcp reno window controller
// depends on tcprwc_pkg, tcprwc_channels, tcprwc_controller, tcprwc_datapath
//
// Reno congestion window controller: each event transaction (duplicate ack,
// new ack, timeout, recovery check) yields one result transaction with the
// retransmit request, window, threshold and recovery flag after the event.
// Window and threshold are unsigned fixed point with FRAC_BITS fraction bits.
// After reset the configured initial window and threshold are loaded in the
// init state, and events are taken from then on, one at a time. An accepted
// event passes through the decide and commit states, and its result is
// registered at commit; the next event is accepted once the controller is back
// in idle. A new ack outside slow start also runs the bit-serial reciprocal
// divider, 2*FRAC_BITS+1 steps, in the divide state before commit.
// The next event is accepted while an earlier result still waits in the
// output register; its own result is held back until that one is taken.
`include "tcp_reno_window_control_defines.svh"

module tcp_reno_window_control #(
    parameter int FRAC_BITS = tcprwc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tcprwc_event_if.sink                       events,
    tcprwc_result_if.source                    results,
    input  logic                               cfg_we,
    input  logic [tcprwc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcprwc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    tcprwc_pkg::ctl_cmd_t    ctl;
    tcprwc_pkg::ctl_status_t status;
    logic                    ev_taken;
    logic                    rtx_shown;

    // sequencing and handshakes
    tcprwc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (events.valid),
        .in_ready  (events.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .ctl       (ctl)
    );

    // state, arithmetic and result registers
    tcprwc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (events.command),
        .ack_number    (events.ack_number),
        .retransmit    (results.retransmit),
        .window_now    (results.window_now),
        .threshold_now (results.threshold_now),
        .in_recovery   (results.in_recovery)
    );

    // checks
    assign ev_taken  = events.valid && events.ready;
    assign rtx_shown = results.valid && results.retransmit;

    `TCPRWC_ASSERT_NEXT(a_one_at_a_time, ev_taken, !events.ready, "event accepted while busy")
    `TCPRWC_ASSERT_NEXT(a_commit_shows, ctl.commit, results.valid, "result not presented")
    `TCPRWC_ASSERT_NOW(a_rtx_in_recovery, rtx_shown, results.in_recovery, "retransmit while open")
    `TCPRWC_ASSERT_NOW(a_div_blocks_input, status.div_done, !events.ready, "input open in divide")

endmodule
